// File: src/rdq_pkg.sv
`default_nettype none

package rdq_pkg;

    // Default geometry of the ring store.
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed widths of the command and result fields.
    localparam int FUNC_W  = 2;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 5;
    localparam int COUNT_W = 5;

    // Operation codes carried on func.
    localparam logic [FUNC_W-1:0] FUNC_APPEND  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PREPEND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH  = 2'd2;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_EMPTY    = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } state_t;

    // Report from the scan unit to the sequencer.
    typedef struct packed {
        logic done;
        logic found;
    } scan_status_t;

endpackage

`default_nettype wire

// File: src/rdq_store.sv
`default_nettype none

// Entry storage: one write port, one read port with registered read data.
module rdq_store
    import rdq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int AW        = $clog2(DEPTH)
)
(
    input  wire logic                         clk,
    input  wire logic                         wr_en,
    input  wire logic [AW-1:0]                wr_addr,
    input  wire logic signed [DATA_WIDTH-1:0] wr_data,
    input  wire logic                         rd_en,
    input  wire logic [AW-1:0]                rd_addr,
    output logic signed [DATA_WIDTH-1:0]      rd_data
);

    logic signed [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: src/rdq_scan.sv
`default_nettype none

// Linear search engine: walks the ring from the head, one read per cycle,
// and compares each returned word against the key with a single comparator.
module rdq_scan
    import rdq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int AW        = $clog2(DEPTH),
    localparam int CW        = $clog2(DEPTH + 1)
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [AW-1:0]                head_idx,
    input  wire logic [CW-1:0]                count,
    input  wire logic signed [DATA_WIDTH-1:0] key,
    output logic                              rd_en,
    output logic [AW-1:0]                     rd_addr,
    input  wire logic signed [DATA_WIDTH-1:0] rd_data,
    output scan_status_t                      scan_status,
    output logic [CW-1:0]                     position
);

    logic                         active_reg, active_next;
    logic                         pend_reg, pend_next;
    logic [AW-1:0]                ptr_reg, ptr_next;
    logic [CW-1:0]                left_reg, left_next;
    logic [CW-1:0]                issue_pos_reg, issue_pos_next;
    logic [CW-1:0]                pos_reg, pos_next;
    logic signed [DATA_WIDTH-1:0] key_reg, key_next;
    logic                         match;
    logic                         finish;

    assign rd_en   = active_reg && (left_reg != '0);
    assign rd_addr = ptr_reg;
    assign match   = active_reg && pend_reg && (rd_data == key_reg);
    assign finish  = active_reg && (match || (left_reg == '0));

    assign scan_status.done  = finish;
    assign scan_status.found = match;
    assign position          = pos_reg;

    always_comb
    begin
        active_next    = active_reg;
        pend_next      = pend_reg;
        ptr_next       = ptr_reg;
        left_next      = left_reg;
        issue_pos_next = issue_pos_reg;
        pos_next       = pos_reg;
        key_next       = key_reg;
        if (start)
        begin
            active_next    = 1'b1;
            pend_next      = 1'b0;
            ptr_next       = head_idx;
            left_next      = count;
            issue_pos_next = CW'(1);
            key_next       = key;
        end
        else if (finish)
        begin
            active_next = 1'b0;
            pend_next   = 1'b0;
        end
        else
        begin
            pend_next = rd_en;
            if (rd_en)
            begin
                ptr_next       = (ptr_reg == AW'(DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
                left_next      = left_reg - 1'b1;
                issue_pos_next = issue_pos_reg + 1'b1;
                pos_next       = issue_pos_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        left_reg      <= left_next;
        issue_pos_reg <= issue_pos_next;
        pos_reg       <= pos_next;
        key_reg       <= key_next;
    end

endmodule

`default_nettype wire

// File: src/ring_deque_with_search_core.sv
`default_nettype none

// Bounded ring deque of signed words with linear search. A command transfer
// takes place at the rising edge where start is high and busy is low; func
// selects append at tail, prepend at head or search for the key in value.
// Exactly one result follows each command, shown for a single cycle while
// done is high; the receiver cannot hold it off, so it must capture the
// result in that cycle. An append, a prepend, a search of an empty store or
// the unused func code returns its result in the cycle after the transfer,
// and the block takes the next command in the cycle after that. A search of
// N stored entries reads the store one entry per cycle through its single
// read port and checks each word with one comparator; it reports the first
// match by its position from the head, or a miss once all N are read. Every
// result carries the head word, the tail word (both zero when empty) and the
// entry count as they stand after the command. The store needs no clearing
// after reset.
module ring_deque_with_search_core
    import rdq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [FUNC_W-1:0]         func,
    input  wire logic signed [VALUE_W-1:0] value,
    output logic                           done,
    output logic [1:0]                     status,
    output logic [POS_W-1:0]               position,
    output logic signed [VALUE_W-1:0]      head_value,
    output logic signed [VALUE_W-1:0]      tail_value,
    output logic [COUNT_W-1:0]             entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    state_t                       state_reg, state_next;
    logic [AW-1:0]                head_idx_reg, head_idx_next;
    logic [CW-1:0]                count_reg, count_next;
    logic signed [DATA_WIDTH-1:0] head_word_reg, head_word_next;
    logic signed [DATA_WIDTH-1:0] tail_word_reg, tail_word_next;
    status_t                      status_reg, status_next;
    logic [CW-1:0]                position_reg, position_next;

    logic                         accept;
    logic                         scan_start;
    logic                         is_full;
    logic                         is_empty;
    logic signed [DATA_WIDTH-1:0] in_word;
    logic [AW-1:0]                head_dec;
    logic [SW-1:0]                tail_sum;
    logic [SW-1:0]                tail_wrap;
    logic [AW-1:0]                tail_slot;

    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic                         mem_re;
    logic [AW-1:0]                mem_raddr;
    logic signed [DATA_WIDTH-1:0] mem_rdata;

    scan_status_t                 scan_status;
    logic [CW-1:0]                scan_pos;

    // The command word is sign-extended or truncated to the stored width.
    assign in_word  = DATA_WIDTH'(value);
    assign accept   = start && !busy;
    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);

    // Slot in front of the head, with wrap.
    assign head_dec = (head_idx_reg == '0) ? AW'(DEPTH - 1) : head_idx_reg - 1'b1;

    // Slot behind the tail: head plus count stays below twice the depth,
    // so one compare and subtract wraps it.
    assign tail_sum  = SW'(head_idx_reg) + SW'(count_reg);
    assign tail_wrap = (tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum;
    assign tail_slot = tail_wrap[AW-1:0];

    // Store writes happen only on the transfer of an insert that fits.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = tail_slot;
        if (accept && !is_full)
        begin
            case (func)
                FUNC_APPEND:
                begin
                    mem_we    = 1'b1;
                    mem_waddr = tail_slot;
                end
                FUNC_PREPEND:
                begin
                    mem_we    = 1'b1;
                    mem_waddr = head_dec;
                end
                default:
                begin
                    mem_we = 1'b0;
                end
            endcase
        end
    end

    rdq_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (in_word),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    rdq_scan #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (scan_start),
        .head_idx    (head_idx_reg),
        .count       (count_reg),
        .key         (in_word),
        .rd_en       (mem_re),
        .rd_addr     (mem_raddr),
        .rd_data     (mem_rdata),
        .scan_status (scan_status),
        .position    (scan_pos)
    );

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (func == FUNC_SEARCH && !is_empty) ? ST_SCAN : ST_RESP;
                end
            end
            ST_SCAN:
            begin
                if (scan_status.done)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic of the sequencer.
    always_comb
    begin
        busy       = 1'b1;
        done       = 1'b0;
        scan_start = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy       = 1'b0;
                scan_start = start && (func == FUNC_SEARCH) && !is_empty;
            end
            ST_SCAN:
            begin
                busy = 1'b1;
            end
            ST_RESP:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // Deque bookkeeping and the result registers.
    always_comb
    begin
        head_idx_next  = head_idx_reg;
        count_next     = count_reg;
        head_word_next = head_word_reg;
        tail_word_next = tail_word_reg;
        status_next    = status_reg;
        position_next  = position_reg;
        if (accept)
        begin
            status_next   = STAT_OK;
            position_next = '0;
            case (func)
                FUNC_APPEND:
                begin
                    if (is_full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        count_next     = count_reg + 1'b1;
                        tail_word_next = in_word;
                        if (is_empty)
                        begin
                            head_word_next = in_word;
                        end
                    end
                end
                FUNC_PREPEND:
                begin
                    if (is_full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        count_next     = count_reg + 1'b1;
                        head_idx_next  = head_dec;
                        head_word_next = in_word;
                        if (is_empty)
                        begin
                            tail_word_next = in_word;
                        end
                    end
                end
                FUNC_SEARCH:
                begin
                    if (is_empty)
                    begin
                        status_next = STAT_EMPTY;
                    end
                end
                default:
                begin
                    status_next = STAT_OK;
                end
            endcase
        end
        else if (state_reg == ST_SCAN && scan_status.done)
        begin
            if (scan_status.found)
            begin
                status_next   = STAT_OK;
                position_next = scan_pos;
            end
            else
            begin
                status_next   = STAT_NOTFOUND;
                position_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_idx_reg <= '0;
            count_reg    <= '0;
            status_reg   <= STAT_OK;
            position_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            head_idx_reg <= head_idx_next;
            count_reg    <= count_next;
            status_reg   <= status_next;
            position_reg <= position_next;
        end
    end

    // The cached head and tail words are only shown while the store holds
    // entries, so they need no reset.
    always_ff @(posedge clk)
    begin
        head_word_reg <= head_word_next;
        tail_word_reg <= tail_word_next;
    end

    assign status      = status_reg;
    assign position    = POS_W'(position_reg);
    assign entry_count = COUNT_W'(count_reg);
    assign head_value  = is_empty ? '0 : VALUE_W'(head_word_reg);
    assign tail_value  = is_empty ? '0 : VALUE_W'(tail_word_reg);

endmodule

`default_nettype wire

// File: src/rdq_checker.sv
`default_nettype none

// Port-level checks of the deque's command and result behavior.
module rdq_checker
    import rdq_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      start,
    input wire logic                      busy,
    input wire logic                      done,
    input wire logic [1:0]                status,
    input wire logic [POS_W-1:0]          position,
    input wire logic [COUNT_W-1:0]        entry_count
);

    // A result strobe lasts exactly one cycle.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // A command transfer makes the block busy in the next cycle.
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after a command transfer");

    // Only a result with OK status reports a nonzero position.
    a_position_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STAT_OK) |-> (position == '0))
        else $error("nonzero position with a failing status");

    // An empty report comes only with an empty store.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STAT_EMPTY) |-> (entry_count == '0))
        else $error("empty status with stored entries");

endmodule

bind ring_deque_with_search_core rdq_checker u_rdq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .position    (position),
    .entry_count (entry_count)
);

`default_nettype wire

// File: verif/ring_deque_with_search_core_tb.sv
`timescale 1ns / 100ps

// Testbench for the ring deque with linear search.
//
// A short table of directed commands comes first. It walks the empty store,
// both signed extremes, the unused func code, a fill to capacity with a
// duplicate word, and the rejected inserts into a full store. After that,
// random commands run against the full ring. Every accepted command is run
// through a behavioral copy of the deque, and the result it predicts, or a
// typed row's written-out result, is queued. Each result strobe is then
// compared field by field with the oldest queued result.
module ring_deque_with_search_core_tb;
    import rdq_pkg::*;

    // The package names only the three real operations.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int RING_DEPTH    = DEPTH_DEF;
    localparam int RANDOM_CMDS   = 400;
    localparam int PAUSE_EVERY   = 100;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 200000;

    // One result as the block reports it.
    typedef struct packed {
        status_t            st;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] head;
        logic [VALUE_W-1:0] tail;
        logic [COUNT_W-1:0] cnt;
    } deque_result_t;

    // One row of the directed table. When 'typed' is set, the row carries a
    // result written out by hand. Otherwise the predictor supplies the result.
    typedef struct packed {
        logic [FUNC_W-1:0]  op;
        logic [VALUE_W-1:0] arg;
        logic               typed;
        deque_result_t      want;
    } cmd_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic [FUNC_W-1:0]         func = '0;
    logic signed [VALUE_W-1:0] value = '0;
    logic                      busy;
    logic                      done;
    logic [1:0]                status;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] head_value;
    logic signed [VALUE_W-1:0] tail_value;
    logic [COUNT_W-1:0]        entry_count;

    // This state belongs to the behavioral copy of the deque. The ring is
    // indexed modulo its depth, so the 4-bit head index wraps on its own.
    logic [VALUE_W-1:0]        model_words [RING_DEPTH];
    logic [3:0]                model_head = '0;
    int                        model_count = 0;

    deque_result_t             pending_results [$];
    int                        fail_count = 0;
    int                        cycle_count = 0;

    ring_deque_with_search_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .value       (value),
        .done        (done),
        .status      (status),
        .position    (position),
        .head_value  (head_value),
        .tail_value  (tail_value),
        .entry_count (entry_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // The watchdog counts every cycle of the run. The slowest legal run has
    // about 430 commands, each with its idle gap and a full-miss search, and
    // the limit is many times as long as that run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic deque_result_t make_result(status_t st, int pos,
                                                  logic [VALUE_W-1:0] hd,
                                                  logic [VALUE_W-1:0] tl, int cnt);
        deque_result_t r;
        r.st   = st;
        r.pos  = pos[POS_W-1:0];
        r.head = hd;
        r.tail = tl;
        r.cnt  = cnt[COUNT_W-1:0];
        return r;
    endfunction

    function automatic cmd_row_t cmd_row(logic [FUNC_W-1:0] op, logic [VALUE_W-1:0] arg,
                                         logic typed, deque_result_t want);
        cmd_row_t r;
        r.op    = op;
        r.arg   = arg;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // Returns the word at the given offset from the head in the model ring.
    function automatic logic [VALUE_W-1:0] word_at(int offset);
        return model_words[model_head + offset[3:0]];
    endfunction

    // Applies one command to the model deque and returns the result that it
    // reports. An insert into a full ring changes nothing. The unused func
    // code also changes nothing, but it still reports the ring as it stands.
    function automatic deque_result_t deque_apply(logic [FUNC_W-1:0] op,
                                                  logic [VALUE_W-1:0] arg);
        deque_result_t r;
        logic          hit;
        r = '0;
        r.st = STAT_OK;
        if (op == FUNC_APPEND || op == FUNC_PREPEND)
        begin
            if (model_count >= RING_DEPTH)
            begin
                r.st = STAT_FULL;
            end
            else
            begin
                if (op == FUNC_APPEND)
                begin
                    model_words[model_head + model_count[3:0]] = arg;
                end
                else
                begin
                    model_head = model_head - 4'd1;
                    model_words[model_head] = arg;
                end
                model_count++;
            end
        end
        else if (op == FUNC_SEARCH)
        begin
            if (model_count == 0)
            begin
                r.st = STAT_EMPTY;
            end
            else
            begin
                // The position counts from 1 at the head, and each search
                // starts counting again.
                hit = 1'b0;
                for (int k = 0; k < model_count; k++)
                begin
                    if (!hit && word_at(k) == arg)
                    begin
                        hit   = 1'b1;
                        r.pos = POS_W'(k + 1);
                    end
                end
                r.st = hit ? STAT_OK : STAT_NOTFOUND;
            end
        end
        if (model_count > 0)
        begin
            r.head = word_at(0);
            r.tail = word_at(model_count - 1);
        end
        r.cnt = model_count[COUNT_W-1:0];
        return r;
    endfunction

    // Waits 'gap' idle cycles, then presents one command and holds it until
    // the block takes it. When the gap is zero, start stays high from the
    // previous command, so back-to-back transfers can happen.
    task automatic issue(logic [FUNC_W-1:0] op, logic [VALUE_W-1:0] arg,
                         logic typed, deque_result_t want, int gap);
        deque_result_t predicted;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        func  <= op;
        value <= arg;
        do @(posedge clk); while (busy);
        // The transfer happened at this edge. The model always advances. A
        // typed row replaces the prediction with its written-out result.
        predicted = deque_apply(op, arg);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Holds off new commands until every outstanding result has come back.
    task automatic wait_drain();
        start <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    // The result monitor. The block shows a result for exactly one cycle
    // while done is high, and it cannot be held off. The values read at the
    // rising edge are the ones from the cycle that this edge ends.
    always @(posedge clk)
    begin
        deque_result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no command outstanding");
                fail_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (status !== exp_r.st)
                begin
                    $error("status: expected %0d, actual %0d", exp_r.st, status);
                    fail_count++;
                end
                if (position !== exp_r.pos)
                begin
                    $error("position: expected %0d, actual %0d", exp_r.pos, position);
                    fail_count++;
                end
                if (head_value !== exp_r.head)
                begin
                    $error("head_value: expected %h, actual %h", exp_r.head, head_value);
                    fail_count++;
                end
                if (tail_value !== exp_r.tail)
                begin
                    $error("tail_value: expected %h, actual %h", exp_r.tail, tail_value);
                    fail_count++;
                end
                if (entry_count !== exp_r.cnt)
                begin
                    $error("entry_count: expected %0d, actual %0d", exp_r.cnt, entry_count);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        cmd_row_t           rows [$];
        logic [VALUE_W-1:0] fill_word;
        logic [VALUE_W-1:0] arg;
        logic [FUNC_W-1:0]  op;
        int                 pick;
        int                 gap;

        for (int i = 0; i < RING_DEPTH; i++)
        begin
            model_words[i] = '0;
        end

        // Reset is asserted once, at time zero, and then released.
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The empty store, the unused code, and both signed extremes. These
        // results can be read straight from the behavior, so they are
        // written out here.
        rows.push_back(cmd_row(FUNC_SEARCH, 32'h0000_0000, 1'b1,
                               make_result(STAT_EMPTY, 0, '0, '0, 0)));
        rows.push_back(cmd_row(FUNC_UNUSED, 32'h1234_5678, 1'b1,
                               make_result(STAT_OK, 0, '0, '0, 0)));
        rows.push_back(cmd_row(FUNC_APPEND, 32'h7FFF_FFFF, 1'b1,
                               make_result(STAT_OK, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1)));
        rows.push_back(cmd_row(FUNC_PREPEND, 32'h8000_0000, 1'b1,
                               make_result(STAT_OK, 0, 32'h8000_0000, 32'h7FFF_FFFF, 2)));
        rows.push_back(cmd_row(FUNC_SEARCH, 32'h8000_0000, 1'b1,
                               make_result(STAT_OK, 1, 32'h8000_0000, 32'h7FFF_FFFF, 2)));
        rows.push_back(cmd_row(FUNC_SEARCH, 32'h7FFF_FFFF, 1'b1,
                               make_result(STAT_OK, 2, 32'h8000_0000, 32'h7FFF_FFFF, 2)));
        rows.push_back(cmd_row(FUNC_SEARCH, 32'h0000_0000, 1'b1,
                               make_result(STAT_NOTFOUND, 0, 32'h8000_0000, 32'h7FFF_FFFF, 2)));
        rows.push_back(cmd_row(FUNC_SEARCH, 32'hFFFF_FFFF, 1'b1,
                               make_result(STAT_NOTFOUND, 0, 32'h8000_0000, 32'h7FFF_FFFF, 2)));

        // Appends and prepends alternate to fill the ring, so the head wraps
        // below index zero. Zero goes in twice, once at each end. The last
        // append leaves a known word at the tail.
        for (int i = 0; i < RING_DEPTH - 2; i++)
        begin
            if (i == 0)
            begin
                fill_word = 32'hFFFF_FFFF;
            end
            else if (i == 1 || i == 2)
            begin
                fill_word = 32'h0000_0000;
            end
            else if (i == RING_DEPTH - 3)
            begin
                fill_word = 32'h5555_AAAA;
            end
            else
            begin
                fill_word = (32'h0F1E_2D3C * i) ^ 32'h8000_0001;
            end
            op = (i % 2 == 1) ? FUNC_PREPEND : FUNC_APPEND;
            if (i == RING_DEPTH - 3)
            begin
                op = FUNC_APPEND;
            end
            rows.push_back(cmd_row(op, fill_word, 1'b0, '0));
        end

        // The ring is full now. Both inserts are rejected. A search for the
        // tail word should report the last position, and a search for zero
        // should find its first copy.
        rows.push_back(cmd_row(FUNC_APPEND, 32'h0000_0001, 1'b0, '0));
        rows.push_back(cmd_row(FUNC_PREPEND, 32'h0000_0001, 1'b0, '0));
        rows.push_back(cmd_row(FUNC_SEARCH, 32'h5555_AAAA, 1'b0, '0));
        rows.push_back(cmd_row(FUNC_SEARCH, 32'h0000_0000, 1'b0, '0));

        foreach (rows[i])
        begin
            issue(rows[i].op, rows[i].arg, rows[i].typed, rows[i].want, $urandom_range(0, 8));
        end

        // Let the directed results all come back before the random traffic.
        wait_drain();

        // Random phase. Inserts can no longer change the ring, so most
        // commands are searches. Keys come from the stored words, from near
        // misses one bit away, from zero and the signed extremes, or from fresh
        // random values. Some stretches run back to back, with no idle cycles.
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            pick = $urandom_range(0, 99);
            op   = FUNC_SEARCH;
            arg  = $urandom;
            if (pick < 45 && model_count > 0)
            begin
                arg = word_at($urandom_range(0, model_count - 1));
            end
            else if (pick < 60)
            begin
                arg = $urandom;
            end
            else if (pick < 70 && model_count > 0)
            begin
                arg = word_at($urandom_range(0, model_count - 1))
                      ^ (32'd1 << $urandom_range(0, VALUE_W - 1));
            end
            else if (pick < 85)
            begin
                op = ($urandom_range(0, 1) == 1) ? FUNC_PREPEND : FUNC_APPEND;
            end
            else if (pick < 95)
            begin
                op = FUNC_UNUSED;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: arg = 32'h0000_0000;
                    1: arg = 32'hFFFF_FFFF;
                    2: arg = 32'h8000_0000;
                    default: arg = 32'h7FFF_FFFF;
                endcase
            end
            gap = ((n / 40) % 3 == 2) ? 0 : $urandom_range(0, 8);
            issue(op, arg, 1'b0, '0, gap);
            if (n % PAUSE_EVERY == PAUSE_EVERY - 1)
            begin
                wait_drain();
            end
        end

        // All commands are in. Wait for the remaining results, then allow a
        // full-miss latency more, so that a stray extra result would be seen.
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_results.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
